FILE: hdl/lcs_pkg.sv
`timescale 1ns / 1ps
// lcs_pkg: shared types, constants and helpers for the luma contrast stretch
// no dependencies; imported by every module of the block
package lcs_pkg;

    // fixed point format of luma: 8 integer bits, LUMA_FRACTION_BITS fraction bits
    localparam int LUMA_FRACTION_BITS = 16;
    localparam int LUMA_W  = 8 + LUMA_FRACTION_BITS;
    localparam int COEF_W  = LUMA_FRACTION_BITS + 1;
    localparam int PROD_W  = COEF_W + 8;
    localparam int SUM_W   = PROD_W + 2;

    // bt.601 weights, rounded to the fraction width
    localparam logic [COEF_W-1:0] COEF_R =
        COEF_W'((299 * (longint'(1) << LUMA_FRACTION_BITS) + 500) / 1000);
    localparam logic [COEF_W-1:0] COEF_G =
        COEF_W'((587 * (longint'(1) << LUMA_FRACTION_BITS) + 500) / 1000);
    localparam logic [COEF_W-1:0] COEF_B =
        COEF_W'((114 * (longint'(1) << LUMA_FRACTION_BITS) + 500) / 1000);

    // largest legal luma, 255.0
    localparam logic [LUMA_W-1:0] LUMA_TOP = {8'hFF, {LUMA_FRACTION_BITS{1'b0}}};

    // datapath widths of the mapping
    localparam int DIFF_W  = LUMA_W + 1;
    localparam int SPAN_W  = 9;
    localparam int NUM_W   = DIFF_W + SPAN_W;
    localparam int MAG_W   = LUMA_W + 8;
    localparam int CNT_W   = $clog2(MAG_W);
    localparam int Q_W     = MAG_W + 2;
    localparam int DELTA_W = MAG_W + 4;
    localparam int CHAN_W  = DELTA_W + 1;

    // queue between front and back
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // command codes
    localparam logic CMD_MEASURE = 1'b0;
    localparam logic CMD_ADJUST  = 1'b1;

    // configuration register indexes
    localparam int  CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_MIN = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_MAX = 1'b1;

    // one adjust pixel on its way to the back end
    typedef struct packed {
        logic [7:0]               red;
        logic [7:0]               green;
        logic [7:0]               blue;
        logic [LUMA_W-1:0]        luma;
        logic signed [DIFF_W-1:0] diff;
        logic [LUMA_W-1:0]        den;
        logic                     flat;
    } lcs_entry_t;

    // queue status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } lcs_q_stat_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_MULT,
        FR_SUM,
        FR_APPLY
    } fr_state_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_ROUND,
        BK_LOAD
    } bk_state_t;

    // round a fixed point value half away from zero, clamp to 0..255
    function automatic logic [7:0] to_channel(input logic signed [CHAN_W-1:0] v);
        logic [CHAN_W-1:0] s;
        logic [CHAN_W-1:0] m;
        logic [7:0]        r;
        s = CHAN_W'(v) + CHAN_W'(1 << (LUMA_FRACTION_BITS - 1));
        m = s >> LUMA_FRACTION_BITS;
        if (v[CHAN_W-1])
        begin
            r = 8'd0;
        end
        else if (m > CHAN_W'(255))
        begin
            r = 8'hFF;
        end
        else
        begin
            r = m[7:0];
        end
        return r;
    endfunction

endpackage

FILE: hdl/luma_contrast_stretch.sv
`timescale 1ns / 1ps
// luma_contrast_stretch: top level; the front end runs a pixel through mult, sum, apply
// an adjust pixel then passes the queue and the back end; the back end takes a new one
// only once the last is loaded, and flat ones skip the 32-step serial divider
// a two-entry queue lets measure pixels stream while the divider works
// reset (rst_n, async, low) sets out_min 0, out_max 255, empty range; no clearing pass
// depends on lcs_pkg, lcs_front, lcs_fifo, lcs_back
module luma_contrast_stretch
    import lcs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   command,
    input  logic                   frame_start,
    input  logic [7:0]             red_in,
    input  logic [7:0]             green_in,
    input  logic [7:0]             blue_in,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             red_out,
    output logic [7:0]             green_out,
    output logic [7:0]             blue_out,
    output logic                   flat_frame,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data
);

    logic [7:0]  out_min_reg;
    logic [7:0]  out_max_reg;
    logic        push;
    logic        pop;
    lcs_entry_t  push_entry;
    lcs_entry_t  head;
    lcs_q_stat_t q_stat;

    // configuration writes, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_min_reg <= 8'd0;
            out_max_reg <= 8'hFF;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_OUT_MIN:
                begin
                    out_min_reg <= cfg_data;
                end
                REG_OUT_MAX:
                begin
                    out_max_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // front end: luma and range
    lcs_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .frame_start (frame_start),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .q_stat      (q_stat),
        .push        (push),
        .push_entry  (push_entry)
    );

    // queue of adjust pixels
    lcs_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .stat       (q_stat)
    );

    // back end: map, divide, round, output beat
    lcs_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_stat     (q_stat),
        .pop        (pop),
        .out_min    (out_min_reg),
        .out_max    (out_max_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out),
        .flat_frame (flat_frame)
    );

endmodule

FILE: hdl/lcs_fifo.sv
`timescale 1ns / 1ps
// lcs_fifo: short queue of adjust pixels between the front and back ends
// depends on lcs_pkg
module lcs_fifo
    import lcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  lcs_entry_t  push_entry,
    input  logic        pop,
    output lcs_entry_t  head,
    output lcs_q_stat_t stat
);

    lcs_entry_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    // status
    assign stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign stat.empty = (count_reg == '0);
    assign head       = mem_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: hdl/lcs_front.sv
`timescale 1ns / 1ps
// lcs_front: accepts pixels, computes luma, tracks min and max, queues adjust pixels
// depends on lcs_pkg
module lcs_front
    import lcs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              command,
    input  logic              frame_start,
    input  logic [7:0]        red_in,
    input  logic [7:0]        green_in,
    input  logic [7:0]        blue_in,
    input  lcs_q_stat_t       q_stat,
    output logic              push,
    output lcs_entry_t        push_entry
);

    fr_state_t          state_reg;
    fr_state_t          state_next;
    logic               cmd_reg;
    logic               start_reg;
    logic [7:0]         red_reg;
    logic [7:0]         green_reg;
    logic [7:0]         blue_reg;
    logic [PROD_W-1:0]  prod_r_reg;
    logic [PROD_W-1:0]  prod_g_reg;
    logic [PROD_W-1:0]  prod_b_reg;
    logic [LUMA_W-1:0]  y_reg;
    logic [LUMA_W-1:0]  y_next;
    logic [SUM_W-1:0]   sum;
    logic [LUMA_W-1:0]  min_reg;
    logic [LUMA_W-1:0]  max_reg;
    logic               accept;
    logic               measure_apply;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FR_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = FR_MULT;
                end
            end
            FR_MULT:
            begin
                state_next = FR_SUM;
            end
            FR_SUM:
            begin
                state_next = FR_APPLY;
            end
            FR_APPLY:
            begin
                if (cmd_reg == CMD_MEASURE || !q_stat.full)
                begin
                    state_next = FR_IDLE;
                end
            end
            default:
            begin
                state_next = FR_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall      = 1'b1;
        push          = 1'b0;
        measure_apply = 1'b0;
        case (state_reg)
            FR_IDLE:
            begin
                in_stall = 1'b0;
            end
            FR_APPLY:
            begin
                push          = (cmd_reg == CMD_ADJUST) && !q_stat.full;
                measure_apply = (cmd_reg == CMD_MEASURE);
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign accept = in_valid && !in_stall;

    // luma sum with saturation
    assign sum = SUM_W'(prod_r_reg) + SUM_W'(prod_g_reg) + SUM_W'(prod_b_reg);
    assign y_next = (sum > SUM_W'(LUMA_TOP)) ? LUMA_TOP : sum[LUMA_W-1:0];

    // entry for the back end, with the range seen by this pixel
    assign push_entry.red   = red_reg;
    assign push_entry.green = green_reg;
    assign push_entry.blue  = blue_reg;
    assign push_entry.luma  = y_reg;
    assign push_entry.diff  = $signed({1'b0, y_reg}) - $signed({1'b0, min_reg});
    assign push_entry.den   = max_reg - min_reg;
    assign push_entry.flat  = (max_reg <= min_reg);

    // state and range registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
            min_reg   <= '1;
            max_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (measure_apply)
            begin
                if (start_reg)
                begin
                    min_reg <= y_reg;
                    max_reg <= y_reg;
                end
                else
                begin
                    if (y_reg < min_reg)
                    begin
                        min_reg <= y_reg;
                    end
                    if (y_reg > max_reg)
                    begin
                        max_reg <= y_reg;
                    end
                end
            end
        end
    end

    // pixel and luma datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= command;
            start_reg <= frame_start;
            red_reg   <= red_in;
            green_reg <= green_in;
            blue_reg  <= blue_in;
        end
        if (state_reg == FR_MULT)
        begin
            prod_r_reg <= PROD_W'(COEF_R) * PROD_W'(red_reg);
            prod_g_reg <= PROD_W'(COEF_G) * PROD_W'(green_reg);
            prod_b_reg <= PROD_W'(COEF_B) * PROD_W'(blue_reg);
        end
        if (state_reg == FR_SUM)
        begin
            y_reg <= y_next;
        end
    end

    // a measured pixel always leaves an ordered range
    assert property (@(posedge clk) disable iff (!rst_n)
        measure_apply |=> (min_reg <= max_reg))
        else $error("luma range out of order after measure");

    // only adjust pixels enter the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (cmd_reg == CMD_ADJUST) && !q_stat.full)
        else $error("bad push into queue");

    // luma stays within 0..255
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FR_APPLY) |-> (y_reg <= LUMA_TOP))
        else $error("luma above 255");

endmodule

FILE: hdl/lcs_back.sv
`timescale 1ns / 1ps
// lcs_back: maps queued pixels to the target luma range with a serial divider
// depends on lcs_pkg
module lcs_back
    import lcs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  lcs_entry_t        head,
    input  lcs_q_stat_t       q_stat,
    output logic              pop,
    input  logic [7:0]        out_min,
    input  logic [7:0]        out_max,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        red_out,
    output logic [7:0]        green_out,
    output logic [7:0]        blue_out,
    output logic              flat_frame
);

    bk_state_t                 state_reg;
    bk_state_t                 state_next;
    lcs_entry_t                ent_reg;
    logic [MAG_W-1:0]          mag_reg;
    logic                      neg_reg;
    logic [LUMA_W-1:0]         rem_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic signed [DELTA_W-1:0] delta_reg;
    logic                      out_valid_reg;
    logic [7:0]                red_reg;
    logic [7:0]                green_reg;
    logic [7:0]                blue_reg;
    logic                      flat_reg;

    logic                      out_free;
    logic                      load;
    logic signed [SPAN_W-1:0]  span;
    logic signed [NUM_W-1:0]   num;
    logic [LUMA_W:0]           trial;
    logic                      ge;
    logic [LUMA_W:0]           trial_sub;
    logic                      round_up;
    logic [MAG_W:0]            qmag;
    logic signed [Q_W-1:0]     q_pos;
    logic signed [Q_W-1:0]     q_val;
    logic signed [DELTA_W-1:0] delta_next;
    logic signed [CHAN_W-1:0]  delta_ext;
    logic signed [CHAN_W-1:0]  chan_r;
    logic signed [CHAN_W-1:0]  chan_g;
    logic signed [CHAN_W-1:0]  chan_b;

    assign out_free = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = head.flat ? BK_LOAD : BK_MUL;
                end
            end
            BK_MUL:
            begin
                state_next = BK_DIV;
            end
            BK_DIV:
            begin
                if (cnt_reg == CNT_W'(MAG_W - 1))
                begin
                    state_next = BK_ROUND;
                end
            end
            BK_ROUND:
            begin
                state_next = BK_LOAD;
            end
            BK_LOAD:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        pop  = 1'b0;
        load = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                pop = !q_stat.empty;
            end
            BK_LOAD:
            begin
                load = out_free;
            end
            default:
            begin
                pop  = 1'b0;
                load = 1'b0;
            end
        endcase
    end

    // signed numerator (y - min) * (out_max - out_min)
    assign span = $signed({1'b0, out_max}) - $signed({1'b0, out_min});
    assign num  = ent_reg.diff * span;

    // one restoring divide step
    assign trial     = {rem_reg, mag_reg[MAG_W-1]};
    assign ge        = (trial >= {1'b0, ent_reg.den});
    assign trial_sub = trial - {1'b0, ent_reg.den};

    // round quotient half away from zero, form newY - Y
    assign round_up   = ({rem_reg, 1'b0} >= {1'b0, ent_reg.den});
    assign qmag       = {1'b0, mag_reg} + (MAG_W + 1)'(round_up);
    assign q_pos      = $signed({{(Q_W - MAG_W - 1){1'b0}}, qmag});
    assign q_val      = neg_reg ? -q_pos : q_pos;
    assign delta_next = {{(DELTA_W - Q_W){q_val[Q_W-1]}}, q_val}
                      + $signed({{(DELTA_W - LUMA_W){1'b0}}, out_min,
                                 {LUMA_FRACTION_BITS{1'b0}}})
                      - $signed({{(DELTA_W - LUMA_W){1'b0}}, ent_reg.luma});

    // channels plus luma shift
    assign delta_ext = {delta_reg[DELTA_W-1], delta_reg};
    assign chan_r = $signed({{(CHAN_W - LUMA_W){1'b0}}, ent_reg.red,
                             {LUMA_FRACTION_BITS{1'b0}}}) + delta_ext;
    assign chan_g = $signed({{(CHAN_W - LUMA_W){1'b0}}, ent_reg.green,
                             {LUMA_FRACTION_BITS{1'b0}}}) + delta_ext;
    assign chan_b = $signed({{(CHAN_W - LUMA_W){1'b0}}, ent_reg.blue,
                             {LUMA_FRACTION_BITS{1'b0}}}) + delta_ext;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == BK_DIV)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                cnt_reg <= '0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ent_reg <= head;
        end
        case (state_reg)
            BK_MUL:
            begin
                neg_reg <= num[NUM_W-1];
                mag_reg <= num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
                rem_reg <= '0;
            end
            BK_DIV:
            begin
                rem_reg <= ge ? trial_sub[LUMA_W-1:0] : trial[LUMA_W-1:0];
                mag_reg <= {mag_reg[MAG_W-2:0], ge};
            end
            BK_ROUND:
            begin
                delta_reg <= delta_next;
            end
            default:
            begin
            end
        endcase
        if (load)
        begin
            if (ent_reg.flat)
            begin
                red_reg   <= ent_reg.red;
                green_reg <= ent_reg.green;
                blue_reg  <= ent_reg.blue;
                flat_reg  <= 1'b1;
            end
            else
            begin
                red_reg   <= to_channel(chan_r);
                green_reg <= to_channel(chan_g);
                blue_reg  <= to_channel(chan_b);
                flat_reg  <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign red_out    = red_reg;
    assign green_out  = green_reg;
    assign blue_out   = blue_reg;
    assign flat_frame = flat_reg;

    // flat pixels never reach the divider
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DIV) |-> (ent_reg.den != '0))
        else $error("divide by zero range");

    // partial remainder stays below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DIV) |-> (rem_reg < ent_reg.den))
        else $error("divider remainder out of range");

    // a new result beat only comes out of the load step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == BK_LOAD))
        else $error("result beat without load");

endmodule

FILE: bench/tb_luma_contrast_stretch.sv
`timescale 1ns / 1ps
// tb_luma_contrast_stretch: self-checking bench for the luma contrast stretch, with
// its own fixed-point predictor of the measure and adjust passes and randomized frames
// depends on lcs_pkg and luma_contrast_stretch
module tb_luma_contrast_stretch;
    import lcs_pkg::*;

    localparam int     CLK_HALF      = 2;
    localparam int     ITEMS         = 1650;
    localparam int     SETTLE_CYCLES = 64;
    localparam int     PHASE_ITEMS   = 180;
    localparam int     LONG_HOLD     = 300;
    localparam longint LIMIT_NS      = 4000000;

    // fixed-point luma format and bt.601 weights
    localparam int     FRAC      = LUMA_FRACTION_BITS;
    localparam longint ONE       = longint'(1) << FRAC;
    localparam longint HALF      = ONE >> 1;
    localparam longint W_RED     = (299 * ONE + 500) / 1000;
    localparam longint W_GREEN   = (587 * ONE + 500) / 1000;
    localparam longint W_BLUE    = (114 * ONE + 500) / 1000;
    localparam longint LUMA_CEIL = 255 * ONE;
    localparam longint LUMA_FULL = (ONE << 8) - 1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       flat;
    } stretch_pixel_t;

    // predicts adjusted pixels and matches them against result beats
    class stretch_scoreboard;
        longint         target_lo;
        longint         target_hi;
        longint         luma_lo;
        longint         luma_hi;
        stretch_pixel_t expected_q[$];
        int             errors;
        int             measured;
        int             adjusted;
        int             flats;

        function new();
            target_lo = 0;
            target_hi = 255;
            luma_lo   = LUMA_FULL;
            luma_hi   = 0;
            errors    = 0;
            measured  = 0;
            adjusted  = 0;
            flats     = 0;
        endfunction

        function void set_target(logic [CFG_INDEX_W-1:0] idx, logic [7:0] value);
            if (idx == REG_OUT_MIN)
            begin
                target_lo = value;
            end
            else if (idx == REG_OUT_MAX)
            begin
                target_hi = value;
            end
        endfunction

        function longint luma_of_pixel(longint r, longint g, longint b);
            longint y;
            y = W_RED * r + W_GREEN * g + W_BLUE * b;
            if (y > LUMA_CEIL)
                y = LUMA_CEIL;
            return y;
        endfunction

        // half away from zero to an integer, then clamp to 0..255
        function logic [7:0] round_channel(longint v);
            longint m;
            if (v < 0)
                return 8'd0;
            m = (v + HALF) >>> FRAC;
            if (m > 255)
                return 8'hFF;
            return m[7:0];
        endfunction

        function void note_pixel(logic cmd, logic fs, logic [7:0] r, logic [7:0] g,
                                 logic [7:0] b);
            longint         lr;
            longint         lg;
            longint         lb;
            longint         y;
            longint         num;
            longint         den;
            longint         mag;
            longint         rem;
            longint         q;
            longint         delta;
            stretch_pixel_t px;
            lr = r;
            lg = g;
            lb = b;
            y  = luma_of_pixel(lr, lg, lb);
            // measure pass: fold luma into the running range
            if (cmd == CMD_MEASURE)
            begin
                measured++;
                if (fs)
                begin
                    luma_lo = y;
                    luma_hi = y;
                end
                else
                begin
                    if (y < luma_lo)
                        luma_lo = y;
                    if (y > luma_hi)
                        luma_hi = y;
                end
                return;
            end
            adjusted++;
            // empty or unmeasured range passes the pixel through
            if (luma_hi <= luma_lo)
            begin
                px = '{r, g, b, 1'b1};
                flats++;
                expected_q.push_back(px);
                return;
            end
            // signed linear map of luma, quotient rounded half away from zero
            num = (y - luma_lo) * (target_hi - target_lo);
            den = luma_hi - luma_lo;
            mag = (num < 0) ? -num : num;
            rem = mag % den;
            mag = mag / den;
            if (2 * rem >= den)
                mag++;
            q     = (num < 0) ? -mag : mag;
            delta = target_lo * ONE + q - y;
            px.red   = round_channel(lr * ONE + delta);
            px.green = round_channel(lg * ONE + delta);
            px.blue  = round_channel(lb * ONE + delta);
            px.flat  = 1'b0;
            expected_q.push_back(px);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic flat);
            stretch_pixel_t want;
            if (expected_q.size() == 0)
            begin
                $error("result beat with nothing expected: %0d %0d %0d flat %0d",
                       r, g, b, flat);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("red_out", want.red, r);
            compare_field("green_out", want.green, g);
            compare_field("blue_out", want.blue, b);
            compare_field("flat_frame", want.flat, flat);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic                   command;
    logic                   frame_start;
    logic [7:0]             red_in;
    logic [7:0]             green_in;
    logic [7:0]             blue_in;
    logic                   out_valid;
    logic                   out_stall;
    logic [7:0]             red_out;
    logic [7:0]             green_out;
    logic [7:0]             blue_out;
    logic                   flat_frame;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [7:0]             cfg_data;

    stretch_scoreboard sb = new();
    logic              burst = 1'b0;
    int                long_hold = 0;
    int                settings_used = 0;

    luma_contrast_stretch u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .frame_start (frame_start),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out),
        .flat_frame  (flat_frame),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    // check every result beat taken
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_pixel(red_out, green_out, blue_out, flat_frame);
    end

    // result side: random hold-off before each beat outside bursts, one long hold on request
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(negedge clk);
        forever
        begin
            if (long_hold > 0)
            begin
                n         = long_hold;
                long_hold = 0;
            end
            else if (burst)
            begin
                n = 0;
            end
            else
            begin
                n = $urandom_range(0, 18);
            end
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while (!out_valid);
            @(negedge clk);
        end
    end

    // one pixel beat; valid stays high when the next beat follows with no gap
    task automatic send_pixel(input logic cmd, input logic fs, input logic [7:0] r,
                              input logic [7:0] g, input logic [7:0] b);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 18);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        frame_start <= fs;
        red_in      <= r;
        green_in    <= g;
        blue_in     <= b;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        sb.note_pixel(command, frame_start, red_in, green_in, blue_in);
    endtask

    // stop sending, wait for every result, then let trailing measure pixels finish
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_target(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        sb.set_target(idx, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_targets(input logic [7:0] lo, input logic [7:0] hi);
        settle();
        if ($urandom_range(0, 1) == 0)
        begin
            write_target(REG_OUT_MIN, lo);
            write_target(REG_OUT_MAX, hi);
        end
        else
        begin
            write_target(REG_OUT_MAX, hi);
            write_target(REG_OUT_MIN, lo);
        end
        settings_used++;
    endtask

    // pixel content: full random, narrow cluster, saturated channels or near gray
    task automatic pick_pixel(input int style, input int base, output logic [7:0] r,
                              output logic [7:0] g, output logic [7:0] b);
        int c[3];
        int v;
        v = $urandom_range(0, 255);
        for (int i = 0; i < 3; i++)
        begin
            case (style)
                0: c[i] = $urandom_range(0, 255);
                1: c[i] = base + $urandom_range(0, 12) - 6;
                2:
                begin
                    case ($urandom_range(0, 2))
                        0: c[i] = 0;
                        1: c[i] = 255;
                        default: c[i] = $urandom_range(0, 255);
                    endcase
                end
                default: c[i] = v + $urandom_range(0, 2) - 1;
            endcase
            if (c[i] < 0)
                c[i] = 0;
            if (c[i] > 255)
                c[i] = 255;
        end
        r = c[0][7:0];
        g = c[1][7:0];
        b = c[2][7:0];
    endtask

    // one frame: mostly measure-then-adjust, some flat, continued or scrambled ones
    task automatic run_frame();
        int         kind;
        int         style;
        int         base;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        kind  = $urandom_range(0, 9);
        style = $urandom_range(0, 3);
        base  = $urandom_range(0, 255);
        burst = ($urandom_range(0, 5) == 0);
        if (kind <= 6)
        begin
            pick_pixel(style, base, r, g, b);
            send_pixel(CMD_MEASURE, 1'b1, r, g, b);
            repeat ($urandom_range(0, 12))
            begin
                pick_pixel(style, base, r, g, b);
                send_pixel(CMD_MEASURE, 1'b0, r, g, b);
            end
            repeat ($urandom_range(1, 16))
            begin
                pick_pixel($urandom_range(0, 3), base, r, g, b);
                send_pixel(CMD_ADJUST, 1'($urandom_range(0, 1)), r, g, b);
            end
        end
        else if (kind == 7)
        begin
            // flat frame: every measured pixel has the same luma
            pick_pixel(style, base, r, g, b);
            send_pixel(CMD_MEASURE, 1'b1, r, g, b);
            repeat ($urandom_range(0, 3))
                send_pixel(CMD_MEASURE, 1'b0, r, g, b);
            repeat ($urandom_range(1, 6))
            begin
                pick_pixel($urandom_range(0, 3), base, r, g, b);
                send_pixel(CMD_ADJUST, 1'($urandom_range(0, 1)), r, g, b);
            end
        end
        else if (kind == 8)
        begin
            // widen the range of the previous frame
            repeat ($urandom_range(1, 4))
            begin
                pick_pixel(style, base, r, g, b);
                send_pixel(CMD_MEASURE, 1'b0, r, g, b);
            end
            repeat ($urandom_range(1, 4))
            begin
                pick_pixel(style, base, r, g, b);
                send_pixel(CMD_ADJUST, 1'($urandom_range(0, 1)), r, g, b);
            end
        end
        else
        begin
            repeat ($urandom_range(1, 8))
            begin
                pick_pixel(style, base, r, g, b);
                send_pixel(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), r, g, b);
            end
        end
        burst = 1'b0;
    endtask

    // fill the block while the result side holds off
    task automatic fill_under_hold();
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        settle();
        burst = 1'b1;
        send_pixel(CMD_MEASURE, 1'b1, 8'd0, 8'd0, 8'd0);
        send_pixel(CMD_MEASURE, 1'b0, 8'd255, 8'd255, 8'd255);
        long_hold = LONG_HOLD;
        repeat (12)
        begin
            pick_pixel(0, 0, r, g, b);
            send_pixel(CMD_ADJUST, 1'b0, r, g, b);
        end
        burst = 1'b0;
    endtask

    // run limit
    initial
    begin
        #(LIMIT_NS);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int  phase_mark;
        bit  pressured;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        command     = CMD_MEASURE;
        frame_start = 1'b0;
        red_in      = 8'd0;
        green_in    = 8'd0;
        blue_in     = 8'd0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_OUT_MIN;
        cfg_data    = 8'd0;
        pressured   = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // nothing measured since reset: pass through
        send_pixel(CMD_ADJUST, 1'b0, 8'd0, 8'd128, 8'd255);
        send_pixel(CMD_ADJUST, 1'b1, 8'd255, 8'd255, 8'd255);
        // single-pixel frame gives an empty range
        send_pixel(CMD_MEASURE, 1'b1, 8'd10, 8'd20, 8'd30);
        send_pixel(CMD_ADJUST, 1'b0, 8'd10, 8'd20, 8'd30);
        send_pixel(CMD_ADJUST, 1'b0, 8'd200, 8'd100, 8'd50);
        // full range, primaries and gray; frame_start on an adjust pixel is ignored
        send_pixel(CMD_MEASURE, 1'b1, 8'd0, 8'd0, 8'd0);
        send_pixel(CMD_MEASURE, 1'b0, 8'd255, 8'd255, 8'd255);
        send_pixel(CMD_ADJUST, 1'b0, 8'd0, 8'd0, 8'd0);
        send_pixel(CMD_ADJUST, 1'b0, 8'd255, 8'd255, 8'd255);
        send_pixel(CMD_ADJUST, 1'b0, 8'd255, 8'd0, 8'd0);
        send_pixel(CMD_ADJUST, 1'b1, 8'd0, 8'd255, 8'd0);
        send_pixel(CMD_ADJUST, 1'b0, 8'd0, 8'd0, 8'd255);
        send_pixel(CMD_ADJUST, 1'b0, 8'd128, 8'd128, 8'd128);
        // inverted targets
        apply_targets(8'd255, 8'd0);
        send_pixel(CMD_ADJUST, 1'b0, 8'd0, 8'd0, 8'd0);
        send_pixel(CMD_ADJUST, 1'b0, 8'd255, 8'd255, 8'd255);
        send_pixel(CMD_ADJUST, 1'b0, 8'd255, 8'd0, 8'd0);
        // narrow range: extrapolation on both sides, channels clamped
        apply_targets(8'd16, 8'd235);
        send_pixel(CMD_MEASURE, 1'b1, 8'd100, 8'd100, 8'd100);
        send_pixel(CMD_MEASURE, 1'b0, 8'd120, 8'd120, 8'd120);
        send_pixel(CMD_ADJUST, 1'b0, 8'd0, 8'd0, 8'd0);
        send_pixel(CMD_ADJUST, 1'b0, 8'd255, 8'd255, 8'd255);
        send_pixel(CMD_ADJUST, 1'b0, 8'd110, 8'd10, 8'd250);

        // random frames, target settings rotate through the extremes, video range and random pairs
        phase_mark = 0;
        while (sb.measured + sb.adjusted < ITEMS)
        begin
            if (!pressured && sb.measured + sb.adjusted >= ITEMS / 2)
            begin
                fill_under_hold();
                pressured = 1'b1;
            end
            if (sb.measured + sb.adjusted - phase_mark >= PHASE_ITEMS)
            begin
                case (settings_used % 8)
                    0: apply_targets(8'd0, 8'd255);
                    1: apply_targets(8'd255, 8'd0);
                    2: apply_targets(8'd0, 8'd0);
                    3: apply_targets(8'd255, 8'd255);
                    4: apply_targets(8'd16, 8'd235);
                    5: apply_targets(8'd235, 8'd16);
                    default: apply_targets(8'($urandom_range(0, 255)),
                                           8'($urandom_range(0, 255)));
                endcase
                phase_mark = sb.measured + sb.adjusted;
            end
            run_frame();
        end

        settle();
        $display("covered %0d measure and %0d adjust pixels (%0d passed through flat)",
                 sb.measured, sb.adjusted, sb.flats);
        $display("over %0d target settings, with one long result hold-off",
                 settings_used);
        if (sb.errors == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
